[rtl/core/chol_pkg.sv]
// Shared types, constants and a helper function of the Cholesky linear solver.
`default_nettype none

package chol_pkg;

    // Fixed widths of the item fields
    localparam int DATA_W   = 32;
    localparam int CFG_W    = 5;
    localparam int ACT_W    = 2;
    localparam int IDX_W    = 4;
    localparam int STAT_W   = 2;
    localparam int ACC_W    = 64;
    localparam int SIZE_LIM = 16;

    // Parameter defaults
    localparam int DEF_MAX_DIM   = 16;
    localparam int DEF_FRAC_BITS = 16;

    typedef enum logic [ACT_W-1:0] {
        ACT_WR_A  = 2'd0,
        ACT_WR_B  = 2'd1,
        ACT_SOLVE = 2'd2
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        ST_OK         = 2'd0,
        ST_BAD_MATRIX = 2'd1,
        ST_BAD_PIVOT  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        SRC_A,
        SRC_B,
        SRC_V
    } t_src;

    typedef enum logic [1:0] {
        PH_FACT,
        PH_FWD,
        PH_BACK
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHK_A,
        S_CHK_B,
        S_CHK_C,
        S_INIT_RD,
        S_INIT_LD,
        S_P_RD,
        S_Q_RD,
        S_MUL,
        S_ACC,
        S_FIN,
        S_DIV_LD,
        S_RUN,
        S_WR,
        S_OUT_RD,
        S_OUT_LD,
        S_ERR_SYM,
        S_ERR_PIV
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                a_we;
        logic                a_re;
        logic                b_we;
        logic                b_re;
        logic                g_we;
        logic                g_re;
        logic                v_we;
        logic                v_re;
        t_src                init_src;
        logic                ld_init;
        logic                chk_ld;
        logic                chk_diag;
        logic                ld_opa;
        logic                q_from_v;
        logic                ld_prod;
        logic                acc_sub;
        logic                div_start;
        logic                sqrt_start;
        logic                out_ld;
        logic                out_err;
        logic [IDX_W-1:0]    out_idx;
        logic                out_last;
        t_status             out_status;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic chk_fail;
        logic acc_nonpos;
        logic unit_busy;
        logic out_free;
    } t_dp_stat;

    // Saturate an exact sum to a signed 32-bit value.
    function automatic logic [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic [DATA_W-1:0] res;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            res = 32'h7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            res = 32'h8000_0000;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/chol_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none

module chol_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port share the address.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/chol_datapath.sv]
// Datapath: stores, multiply-accumulate, divider, square root and result register.
`default_nettype none

module chol_datapath #(
    parameter int MAX_DIM   = chol_pkg::DEF_MAX_DIM,
    parameter int FRAC_BITS = chol_pkg::DEF_FRAC_BITS
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire chol_pkg::t_dp_cmd                       i_cmd,
    output chol_pkg::t_dp_stat                           o_stat,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      i_a_addr,
    input  wire logic [$clog2(MAX_DIM)-1:0]              i_b_addr,
    input  wire logic [$clog2(MAX_DIM*MAX_DIM)-1:0]      i_g_addr,
    input  wire logic [$clog2(MAX_DIM)-1:0]              i_v_addr,
    input  wire logic [chol_pkg::DATA_W-1:0]             i_entry_value,
    input  wire logic                                    i_out_stall,
    output logic                                         o_out_valid,
    output logic [chol_pkg::DATA_W-1:0]                  o_solution_value,
    output logic [chol_pkg::IDX_W-1:0]                   o_solution_index,
    output logic                                         o_last_result,
    output logic [chol_pkg::STAT_W-1:0]                  o_status
);
    import chol_pkg::*;

    localparam int MD    = MAX_DIM * MAX_DIM;
    localparam int NW    = DATA_W + FRAC_BITS;
    localparam int SW    = NW + (NW % 2);
    localparam int RW    = SW / 2;
    localparam int CW    = $clog2(NW + 1);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));

    logic [DATA_W-1:0]        a_rd, b_rd, g_rd, v_rd;
    logic [DATA_W-1:0]        wr_data;
    logic signed [DATA_W-1:0] q_opnd;
    logic [DATA_W-1:0]        init_val;
    logic signed [ACC_W-1:0]  prod_rnd;
    logic [DATA_W-1:0]        acc_sat;
    logic [DATA_W-1:0]        m_mag, d_mag;
    logic [DATA_W:0]          rem_sh, rem_diff;
    logic                     div_ge;
    logic [RW+3:0]            srem_sh, s_trial, srem_diff;
    logic                     sq_ge;
    logic [DATA_W-1:0]        div_res;
    logic                     ov_pos, ov_neg;

    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DATA_W-1:0] r_opa;
    logic signed [ACC_W-1:0]  r_prod;
    logic [CW-1:0]            r_cnt;
    logic                     r_mode_root;
    logic [DATA_W-1:0]        r_rem;
    logic [NW-1:0]            r_quo;
    logic [DATA_W-1:0]        r_dmag;
    logic                     r_neg;
    logic                     r_dzero;
    logic [SW-1:0]            r_sv;
    logic [RW+1:0]            r_srem;
    logic [RW-1:0]            r_root;
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_value;
    logic [IDX_W-1:0]         r_out_idx;
    logic                     r_out_last;
    t_status                  r_out_status;

    // Stores of A, b, G and the shared y/x vector
    chol_ram #(.WIDTH(DATA_W), .DEPTH(MD)) u_a_ram (
        .i_clk(i_clk), .i_we(i_cmd.a_we), .i_re(i_cmd.a_re), .i_addr(i_a_addr),
        .i_wdata(i_entry_value), .o_rdata(a_rd)
    );
    chol_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM)) u_b_ram (
        .i_clk(i_clk), .i_we(i_cmd.b_we), .i_re(i_cmd.b_re), .i_addr(i_b_addr),
        .i_wdata(i_entry_value), .o_rdata(b_rd)
    );
    chol_ram #(.WIDTH(DATA_W), .DEPTH(MD)) u_g_ram (
        .i_clk(i_clk), .i_we(i_cmd.g_we), .i_re(i_cmd.g_re), .i_addr(i_g_addr),
        .i_wdata(wr_data), .o_rdata(g_rd)
    );
    chol_ram #(.WIDTH(DATA_W), .DEPTH(MAX_DIM)) u_v_ram (
        .i_clk(i_clk), .i_we(i_cmd.v_we), .i_re(i_cmd.v_re), .i_addr(i_v_addr),
        .i_wdata(wr_data), .o_rdata(v_rd)
    );

    // Operand selection and rounding of the product
    always_comb begin
        q_opnd = i_cmd.q_from_v ? v_rd : g_rd;
        unique case (i_cmd.init_src)
            SRC_A:   init_val = a_rd;
            SRC_B:   init_val = b_rd;
            default: init_val = v_rd;
        endcase
        prod_rnd = (r_prod + HALF) >>> FRAC_BITS;
        acc_sat  = sat_acc(r_acc);
        m_mag    = acc_sat[DATA_W-1] ? (~acc_sat + 1'b1) : acc_sat;
        d_mag    = g_rd[DATA_W-1] ? (~g_rd + 1'b1) : g_rd;
    end

    // One step of the restoring divider and of the root extraction
    always_comb begin
        rem_sh    = {r_rem, r_quo[NW-1]};
        rem_diff  = rem_sh - {1'b0, r_dmag};
        div_ge    = (rem_sh >= {1'b0, r_dmag});
        srem_sh   = {r_srem, r_sv[SW-1 -: 2]};
        s_trial   = {2'b00, r_root, 2'b01};
        srem_diff = srem_sh - s_trial;
        sq_ge     = (srem_sh >= s_trial);
    end

    // Sign and saturation of the quotient
    always_comb begin
        ov_pos = (r_quo > NW'(64'h0000_0000_7FFF_FFFF));
        ov_neg = (r_quo > NW'(64'h0000_0000_8000_0000));
        if (r_dzero) begin
            div_res = '0;
        end else if (r_neg) begin
            div_res = ov_neg ? 32'h8000_0000 : (~r_quo[DATA_W-1:0] + 1'b1);
        end else begin
            div_res = ov_pos ? 32'h7FFF_FFFF : r_quo[DATA_W-1:0];
        end
        wr_data = r_mode_root ? DATA_W'(r_root) : div_res;
    end

    // Accumulator, operand and product registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_init) begin
            r_acc <= {{(ACC_W-DATA_W){init_val[DATA_W-1]}}, init_val};
        end else if (i_cmd.acc_sub) begin
            r_acc <= r_acc - prod_rnd;
        end
        if (i_cmd.ld_opa) begin
            r_opa <= g_rd;
        end else if (i_cmd.chk_ld) begin
            r_opa <= a_rd;
        end
        if (i_cmd.ld_prod) begin
            r_prod <= r_opa * q_opnd;
        end
    end

    // Step counter shared by the divider and the root unit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.div_start) begin
            r_cnt <= CW'(NW);
        end else if (i_cmd.sqrt_start) begin
            r_cnt <= CW'(RW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Divider and root unit payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_mode_root <= 1'b0;
            r_rem       <= '0;
            r_quo       <= {m_mag, {FRAC_BITS{1'b0}}};
            r_dmag      <= d_mag;
            r_neg       <= acc_sat[DATA_W-1] ^ g_rd[DATA_W-1];
            r_dzero     <= (g_rd == '0);
        end else if (i_cmd.sqrt_start) begin
            r_mode_root <= 1'b1;
            r_srem      <= '0;
            r_root      <= '0;
            r_sv        <= SW'({acc_sat, {FRAC_BITS{1'b0}}});
        end else if (r_cnt != '0) begin
            if (r_mode_root) begin
                r_sv   <= r_sv << 2;
                r_srem <= sq_ge ? srem_diff[RW+1:0] : srem_sh[RW+1:0];
                r_root <= {r_root[RW-2:0], sq_ge};
            end else begin
                r_rem <= div_ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[NW-2:0], div_ge};
            end
        end
    end

    // Result register towards the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out_value  <= i_cmd.out_err ? '0 : v_rd;
            r_out_idx    <= i_cmd.out_idx;
            r_out_last   <= i_cmd.out_last;
            r_out_status <= i_cmd.out_status;
        end
    end

    // Status towards the controller
    always_comb begin
        o_stat.chk_fail   = (a_rd != r_opa) || (i_cmd.chk_diag && r_opa[DATA_W-1]);
        o_stat.acc_nonpos = r_acc[ACC_W-1] || (r_acc == '0);
        o_stat.unit_busy  = (r_cnt != '0);
        o_stat.out_free   = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid      = r_out_valid;
    assign o_solution_value = r_out_value;
    assign o_solution_index = r_out_idx;
    assign o_last_result    = r_out_last;
    assign o_status         = r_out_status;

endmodule

`default_nettype wire

[rtl/core/chol_ctrl.sv]
// Controller: sequences the check, factorisation, substitutions and output of a solve.
`default_nettype none

module chol_ctrl #(
    parameter int MAX_DIM = chol_pkg::DEF_MAX_DIM
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire logic [chol_pkg::CFG_W-1:0]              i_matrix_size,
    input  wire logic                                    i_in_valid,
    output logic                                         o_in_stall,
    input  wire logic [chol_pkg::ACT_W-1:0]              i_action,
    input  wire logic [chol_pkg::IDX_W-1:0]              i_row_index,
    input  wire logic [chol_pkg::IDX_W-1:0]              i_col_index,
    input  wire chol_pkg::t_dp_stat                      i_stat,
    output chol_pkg::t_dp_cmd                            o_cmd,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]           o_a_addr,
    output logic [$clog2(MAX_DIM)-1:0]                   o_b_addr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]           o_g_addr,
    output logic [$clog2(MAX_DIM)-1:0]                   o_v_addr
);
    import chol_pkg::*;

    localparam int IW  = $clog2(MAX_DIM);
    localparam int AW  = $clog2(MAX_DIM * MAX_DIM);
    localparam int LIM = (MAX_DIM < SIZE_LIM) ? MAX_DIM : SIZE_LIM;
    localparam logic [CFG_W-1:0] LIM_N = CFG_W'(LIM);

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [IW-1:0]   r_i, n_i;
    logic [IW-1:0]   r_j, n_j;
    logic [IW-1:0]   r_k, n_k;
    logic [CFG_W-1:0] eff_n;
    logic [IW-1:0]   nm1;
    logic            is_diag, has_terms, last_term, in_range, accept;

    function automatic logic [AW-1:0] mat_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
        return AW'(32'(r) * MAX_DIM + 32'(c));
    endfunction

    // Effective order of the system and loop conditions
    always_comb begin
        if (i_matrix_size == '0) begin
            eff_n = CFG_W'(1);
        end else if (i_matrix_size > LIM_N) begin
            eff_n = LIM_N;
        end else begin
            eff_n = i_matrix_size;
        end
        nm1      = IW'(eff_n - 1'b1);
        is_diag  = (r_phase == PH_FACT) && (r_i == r_k);
        in_range = (32'(i_row_index) < MAX_DIM) && (32'(i_col_index) < MAX_DIM);
        accept   = i_in_valid && (r_state == S_IDLE);
        unique case (r_phase)
            PH_FACT: begin
                has_terms = (r_i != '0);
                last_term = (IW'(r_j + 1'b1) == r_i);
            end
            PH_FWD: begin
                has_terms = (r_k != '0);
                last_term = (IW'(r_j + 1'b1) == r_k);
            end
            default: begin
                has_terms = (r_k != nm1);
                last_term = (r_j == nm1);
            end
        endcase
    end

    // Next state and loop indices
    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        unique case (r_state)
            S_IDLE: begin
                if (accept && t_action'(i_action) == ACT_SOLVE) begin
                    n_state = S_CHK_A;
                    n_i     = '0;
                    n_j     = '0;
                end
            end
            S_CHK_A: n_state = S_CHK_B;
            S_CHK_B: n_state = S_CHK_C;
            S_CHK_C: begin
                if (i_stat.chk_fail) begin
                    n_state = S_ERR_SYM;
                end else if (r_j == nm1) begin
                    if (r_i == nm1) begin
                        n_state = S_INIT_RD;
                        n_phase = PH_FACT;
                        n_k     = '0;
                        n_i     = '0;
                    end else begin
                        n_state = S_CHK_A;
                        n_i     = r_i + 1'b1;
                        n_j     = '0;
                    end
                end else begin
                    n_state = S_CHK_A;
                    n_j     = r_j + 1'b1;
                end
            end
            S_INIT_RD: n_state = S_INIT_LD;
            S_INIT_LD: begin
                n_j     = (r_phase == PH_BACK) ? IW'(r_k + 1'b1) : '0;
                n_state = has_terms ? S_P_RD : S_FIN;
            end
            S_P_RD: n_state = S_Q_RD;
            S_Q_RD: n_state = S_MUL;
            S_MUL:  n_state = S_ACC;
            S_ACC: begin
                if (last_term) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_P_RD;
                    n_j     = r_j + 1'b1;
                end
            end
            S_FIN: begin
                if (is_diag) begin
                    n_state = i_stat.acc_nonpos ? S_ERR_PIV : S_RUN;
                end else begin
                    n_state = S_DIV_LD;
                end
            end
            S_DIV_LD: n_state = S_RUN;
            S_RUN: begin
                if (!i_stat.unit_busy) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                n_state = S_INIT_RD;
                unique case (r_phase)
                    PH_FACT: begin
                        if (r_i != r_k) begin
                            n_i = r_i + 1'b1;
                        end else if (r_k == nm1) begin
                            n_phase = PH_FWD;
                            n_k     = '0;
                        end else begin
                            n_k = r_k + 1'b1;
                            n_i = '0;
                        end
                    end
                    PH_FWD: begin
                        if (r_k == nm1) begin
                            n_phase = PH_BACK;
                        end else begin
                            n_k = r_k + 1'b1;
                        end
                    end
                    default: begin
                        if (r_k == '0) begin
                            n_state = S_OUT_RD;
                        end else begin
                            n_k = r_k - 1'b1;
                        end
                    end
                endcase
            end
            S_OUT_RD: n_state = S_OUT_LD;
            S_OUT_LD: begin
                if (i_stat.out_free) begin
                    if (r_k == nm1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_OUT_RD;
                        n_k     = r_k + 1'b1;
                    end
                end
            end
            S_ERR_SYM, S_ERR_PIV: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands and store addresses
    always_comb begin
        o_cmd    = '0;
        o_a_addr = '0;
        o_b_addr = '0;
        o_g_addr = '0;
        o_v_addr = '0;
        unique case (r_state)
            S_IDLE: begin
                o_a_addr = in_range ? mat_addr(IW'(i_row_index), IW'(i_col_index)) : '0;
                o_b_addr = IW'(i_row_index);
                if (accept && t_action'(i_action) == ACT_WR_A) begin
                    o_cmd.a_we = in_range;
                end
                if (accept && t_action'(i_action) == ACT_WR_B) begin
                    o_cmd.b_we = (32'(i_row_index) < MAX_DIM);
                end
            end
            S_CHK_A: begin
                o_cmd.a_re = 1'b1;
                o_a_addr   = mat_addr(r_i, r_j);
            end
            S_CHK_B: begin
                o_cmd.a_re   = 1'b1;
                o_cmd.chk_ld = 1'b1;
                o_a_addr     = mat_addr(r_j, r_i);
            end
            S_CHK_C: o_cmd.chk_diag = (r_i == r_j);
            S_INIT_RD: begin
                o_a_addr = mat_addr(r_k, r_i);
                o_b_addr = r_k;
                o_v_addr = r_k;
                unique case (r_phase)
                    PH_FACT: o_cmd.a_re = 1'b1;
                    PH_FWD:  o_cmd.b_re = 1'b1;
                    default: o_cmd.v_re = 1'b1;
                endcase
            end
            S_INIT_LD: begin
                o_cmd.ld_init = 1'b1;
                unique case (r_phase)
                    PH_FACT: o_cmd.init_src = SRC_A;
                    PH_FWD:  o_cmd.init_src = SRC_B;
                    default: o_cmd.init_src = SRC_V;
                endcase
            end
            S_P_RD: begin
                o_cmd.g_re = 1'b1;
                o_g_addr   = (r_phase == PH_BACK) ? mat_addr(r_j, r_k) : mat_addr(r_k, r_j);
            end
            S_Q_RD: begin
                o_cmd.ld_opa = 1'b1;
                o_g_addr     = mat_addr(r_i, r_j);
                o_v_addr     = r_j;
                if (r_phase == PH_FACT) begin
                    o_cmd.g_re = 1'b1;
                end else begin
                    o_cmd.v_re = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.ld_prod  = 1'b1;
                o_cmd.q_from_v = (r_phase != PH_FACT);
            end
            S_ACC: o_cmd.acc_sub = 1'b1;
            S_FIN: begin
                if (is_diag) begin
                    o_cmd.sqrt_start = !i_stat.acc_nonpos;
                end else begin
                    o_cmd.g_re = 1'b1;
                    o_g_addr   = (r_phase == PH_FACT) ? mat_addr(r_i, r_i)
                                                      : mat_addr(r_k, r_k);
                end
            end
            S_DIV_LD: o_cmd.div_start = 1'b1;
            S_RUN: begin
            end
            S_WR: begin
                o_g_addr = mat_addr(r_k, r_i);
                o_v_addr = r_k;
                if (r_phase == PH_FACT) begin
                    o_cmd.g_we = 1'b1;
                end else begin
                    o_cmd.v_we = 1'b1;
                end
            end
            S_OUT_RD: begin
                o_cmd.v_re = 1'b1;
                o_v_addr   = r_k;
            end
            S_OUT_LD: begin
                o_cmd.out_ld     = i_stat.out_free;
                o_cmd.out_idx    = IDX_W'(r_k);
                o_cmd.out_last   = (r_k == nm1);
                o_cmd.out_status = ST_OK;
            end
            S_ERR_SYM: begin
                o_cmd.out_ld     = i_stat.out_free;
                o_cmd.out_err    = 1'b1;
                o_cmd.out_last   = 1'b1;
                o_cmd.out_status = ST_BAD_MATRIX;
            end
            S_ERR_PIV: begin
                o_cmd.out_ld     = i_stat.out_free;
                o_cmd.out_err    = 1'b1;
                o_cmd.out_last   = 1'b1;
                o_cmd.out_status = ST_BAD_PIVOT;
            end
            default: begin
            end
        endcase
    end

    // State and index registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_FACT;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

[rtl/core/cholesky_linear_solver.sv]
// Top level of the Cholesky linear solver: size register, controller and datapath.
//
// Usage. The input channel (i_in_valid / o_in_stall) takes items that write an
// entry of A (row, column), write an entry of b (row) or start a solve. Writes
// give no result. A solve checks A for symmetry and a non-negative diagonal,
// factors A = G * G^T, runs forward and back substitution and then delivers
// x[0] .. x[n-1] on the output channel (o_out_valid / i_out_stall), the final
// item marked by o_last_result. A failed check or a non-positive pivot gives
// one item with a non-zero status instead. The order n comes from the register
// written through i_cfg_valid / i_cfg_data (o_cfg_ready is always high); the
// user must see that it is written only while the block is idle, as the block
// does not enforce this. A solve runs on a single multiplier and on bit-serial
// divider and root units. The block works on one solve at a time; o_in_stall
// is high from the solve until its last item sits in the output register. A
// stalled output item holds. Reset returns the controller to idle, empties the
// output register and sets the order to 1; the stores keep no reset value.
`default_nettype none

module cholesky_linear_solver #(
    parameter int MAX_DIM   = chol_pkg::DEF_MAX_DIM,
    parameter int FRAC_BITS = chol_pkg::DEF_FRAC_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [chol_pkg::CFG_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [chol_pkg::ACT_W-1:0]    i_action,
    input  wire logic [chol_pkg::IDX_W-1:0]    i_row_index,
    input  wire logic [chol_pkg::IDX_W-1:0]    i_col_index,
    input  wire logic [chol_pkg::DATA_W-1:0]   i_entry_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [chol_pkg::DATA_W-1:0]        o_solution_value,
    output logic [chol_pkg::IDX_W-1:0]         o_solution_index,
    output logic                               o_last_result,
    output logic [chol_pkg::STAT_W-1:0]        o_status
);
    import chol_pkg::*;

    localparam int IW = $clog2(MAX_DIM);
    localparam int AW = $clog2(MAX_DIM * MAX_DIM);

    logic [CFG_W-1:0] r_matrix_size;
    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [AW-1:0]    a_addr, g_addr;
    logic [IW-1:0]    b_addr, v_addr;

    // Order register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_matrix_size <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    chol_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_matrix_size (r_matrix_size),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_row_index   (i_row_index),
        .i_col_index   (i_col_index),
        .i_stat        (stat),
        .o_cmd         (cmd),
        .o_a_addr      (a_addr),
        .o_b_addr      (b_addr),
        .o_g_addr      (g_addr),
        .o_v_addr      (v_addr)
    );

    chol_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_a_addr         (a_addr),
        .i_b_addr         (b_addr),
        .i_g_addr         (g_addr),
        .i_v_addr         (v_addr),
        .i_entry_value    (i_entry_value),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_solution_value (o_solution_value),
        .o_solution_index (o_solution_index),
        .o_last_result    (o_last_result),
        .o_status         (o_status)
    );

endmodule

`default_nettype wire

[rtl/core/chol_checker.sv]
// Port-level checker for the Cholesky linear solver, bound to the top level.
`default_nettype none

module chol_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_cfg_valid,
    input wire logic                          o_cfg_ready,
    input wire logic [chol_pkg::CFG_W-1:0]    i_cfg_data,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_stall,
    input wire logic [chol_pkg::ACT_W-1:0]    i_action,
    input wire logic [chol_pkg::IDX_W-1:0]    i_row_index,
    input wire logic [chol_pkg::IDX_W-1:0]    i_col_index,
    input wire logic [chol_pkg::DATA_W-1:0]   i_entry_value,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_stall,
    input wire logic [chol_pkg::DATA_W-1:0]   o_solution_value,
    input wire logic [chol_pkg::IDX_W-1:0]    o_solution_index,
    input wire logic                          o_last_result,
    input wire logic [chol_pkg::STAT_W-1:0]   o_status
);
    import chol_pkg::*;

    // A stalled result item holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_solution_value)
            && $stable(o_solution_index) && $stable(o_last_result) && $stable(o_status))
        else $error("result item changed while stalled");

    // An accepted solve closes the input channel in the next cycle.
    a_solve_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_action == ACT_SOLVE |=> o_in_stall)
        else $error("input open right after a solve was accepted");

    // While a solve still has items to deliver, no new item is taken.
    a_busy_mid_solve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_result |-> o_in_stall)
        else $error("input open before the last item of a solve");

    // An error item is single, empty and final.
    a_error_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_last_result
            && o_solution_value == '0 && o_solution_index == '0)
        else $error("malformed error item");

endmodule

bind cholesky_linear_solver chol_checker u_chol_checker (.*);

`default_nettype wire

[tb/cholesky_linear_solver_tb.sv]
// Self-checking testbench of the Cholesky linear solver with its own fixed-point predictor.
`default_nettype none

module cholesky_linear_solver_tb;
    import chol_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = DEF_FRAC_BITS;
    localparam int DIM = DEF_MAX_DIM;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int TARGET_ITEMS = 310;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [DATA_W-1:0] val;
    } t_item;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic [IDX_W-1:0]  idx;
        logic              last;
        t_status           st;
    } t_sol;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CFG_W-1:0]    i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    logic [ACT_W-1:0]    i_action = '0;
    logic [IDX_W-1:0]    i_row_index = '0;
    logic [IDX_W-1:0]    i_col_index = '0;
    logic [DATA_W-1:0]   i_entry_value = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [DATA_W-1:0]   o_solution_value;
    logic [IDX_W-1:0]    o_solution_index;
    logic                o_last_result;
    logic [STAT_W-1:0]   o_status;

    cholesky_linear_solver dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_row_index      (i_row_index),
        .i_col_index      (i_col_index),
        .i_entry_value    (i_entry_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_solution_value (o_solution_value),
        .o_solution_index (o_solution_index),
        .o_last_result    (o_last_result),
        .o_status         (o_status)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state: the system as the block should hold it.
    logic [CFG_W-1:0] order_reg = 5'd1;
    int a_mat [DIM][DIM];
    int b_vec [DIM];
    int g_fac [DIM][DIM];
    int y_vec [DIM];
    int x_vec [DIM];
    t_sol x_expect [$];

    t_item pending [$];
    int gen_a [DIM][DIM];
    int issued = 0;
    int send_gap_max = 0;
    int rx_gap_max = 0;
    int long_req = 0;
    int errors = 0;
    int n_solves = 0;
    int n_results = 0;
    int n_failed = 0;

    function automatic int clip32(longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return int'(v);
    endfunction

    // Product rounded to nearest, ties upward, then scaled back.
    function automatic longint mul_q(int a, int b);
        longint p;
        p = longint'(a) * longint'(b);
        return (p + (64'sd1 <<< (FB - 1))) >>> FB;
    endfunction

    function automatic int div_q(longint m, int d);
        longint num;
        num = longint'(clip32(m)) * (64'sd1 <<< FB);
        if (d == 0) return 0;
        return clip32(num / longint'(d));
    endfunction

    function automatic int root_q(int s);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bt;
        v = {32'd0, s} << FB;
        r = '0;
        bt = 64'h4000_0000_0000_0000;
        while (bt > v) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return clip32(longint'(r));
    endfunction

    function automatic void push_error(t_status st);
        t_sol e;
        e.value = '0;
        e.idx = '0;
        e.last = 1'b1;
        e.st = st;
        x_expect.push_back(e);
    endfunction

    // Check, factor, substitute forward and back, and queue x.
    function automatic void predict_solution();
        int n;
        longint acc;
        t_sol e;
        n = (order_reg == 0) ? 1 : (order_reg > DIM) ? DIM : int'(order_reg);
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < n; j++) begin
                if (a_mat[i][j] != a_mat[j][i]) begin
                    push_error(ST_BAD_MATRIX);
                    return;
                end
            end
            if (a_mat[i][i] < 0) begin
                push_error(ST_BAD_MATRIX);
                return;
            end
        end
        for (int k = 0; k < n; k++) begin
            for (int i = 0; i < n; i++) begin
                if (i < k) begin
                    acc = a_mat[k][i];
                    for (int j = 0; j < i; j++) acc -= mul_q(g_fac[k][j], g_fac[i][j]);
                    g_fac[k][i] = div_q(acc, g_fac[i][i]);
                end else if (i == k) begin
                    acc = a_mat[k][k];
                    for (int j = 0; j < k; j++) acc -= mul_q(g_fac[k][j], g_fac[k][j]);
                    if (acc <= 0) begin
                        push_error(ST_BAD_PIVOT);
                        return;
                    end
                    g_fac[k][k] = root_q(clip32(acc));
                end else begin
                    g_fac[k][i] = 0;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            acc = b_vec[k];
            for (int j = 0; j < k; j++) acc -= mul_q(g_fac[k][j], y_vec[j]);
            y_vec[k] = div_q(acc, g_fac[k][k]);
        end
        for (int k = n - 1; k >= 0; k--) begin
            acc = y_vec[k];
            for (int j = k + 1; j < n; j++) acc -= mul_q(g_fac[j][k], x_vec[j]);
            x_vec[k] = div_q(acc, g_fac[k][k]);
        end
        for (int k = 0; k < n; k++) begin
            e.value = x_vec[k];
            e.idx = k[IDX_W-1:0];
            e.last = (k == n - 1);
            e.st = ST_OK;
            x_expect.push_back(e);
        end
    endfunction

    task automatic report(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        $display("mismatch at %0t: %s got %h, wanted %h", $realtime, what, got, want);
        errors++;
    endtask

    // Input driver: offers queued items with random gaps between them.
    int gap_left = 0;
    always @(posedge i_clk) begin
        logic take;
        t_item it;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left <= 0;
        end else begin
            take = i_in_valid && !o_in_stall;
            if (take) begin
                case (i_action)
                    ACT_WR_A:  a_mat[i_row_index][i_col_index] = i_entry_value;
                    ACT_WR_B:  b_vec[i_row_index] = i_entry_value;
                    ACT_SOLVE: begin
                        n_solves++;
                        predict_solution();
                    end
                    default: ;
                endcase
            end
            if (i_in_valid && !take) begin
                // Stalled item holds.
            end else if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending.size() != 0) begin
                it = pending.pop_front();
                i_action <= it.act;
                i_row_index <= it.row;
                i_col_index <= it.col;
                i_entry_value <= it.val;
                i_in_valid <= 1'b1;
                gap_left <= $urandom_range(0, send_gap_max);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Long hold of the output, counted on its own; armed by the stimulus and
    // started once a result item is waiting.
    int long_left = 0;
    int long_seen = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            long_left <= 0;
        end else if (long_seen != long_req && o_out_valid) begin
            long_seen <= long_req;
            long_left <= 400;
        end else if (long_left > 0) begin
            long_left <= long_left - 1;
        end
    end

    // Output monitor: checks each result and stalls at random or for a long hold.
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_sol e;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                n_results++;
                if (o_status != ST_OK) n_failed++;
                if (x_expect.size() == 0) begin
                    report("unexpected item, value", o_solution_value, '0);
                end else begin
                    e = x_expect.pop_front();
                    if (o_solution_value !== e.value) report("value", o_solution_value, e.value);
                    if (o_solution_index !== e.idx) report("index", o_solution_index, e.idx);
                    if (o_last_result !== e.last) report("last", o_last_result, e.last);
                    if (o_status !== e.st) report("status", o_status, e.st);
                end
                stall_left = $urandom_range(0, rx_gap_max);
            end
            if (long_left > 0) begin
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic push_item(logic [ACT_W-1:0] act, int row, int col, int val);
        t_item it;
        it.act = act;
        it.row = row[IDX_W-1:0];
        it.col = col[IDX_W-1:0];
        it.val = val;
        pending.push_back(it);
        if (act != ACT_UNUSED) issued++;
        if (act == ACT_WR_A) gen_a[row][col] = val;
    endtask

    task automatic push_solve();
        push_item(ACT_SOLVE, $urandom_range(0, 15), $urandom_range(0, 15), $urandom);
    endtask

    task automatic drain();
        while (pending.size() != 0 || i_in_valid || x_expect.size() != 0) @(negedge i_clk);
        repeat (64) @(negedge i_clk);
    endtask

    task automatic set_order(logic [CFG_W-1:0] v);
        drain();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        order_reg = v;
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Load the leading n x n block and b, then solve. Kinds: 0 well conditioned,
    // 1 asymmetric, 2 negative diagonal, 3 zero pivot, 4 wild symmetric values.
    task automatic load_system(int n, int kind);
        int v;
        int i;
        int j;
        for (int r = 0; r < n; r++) begin
            for (int c = 0; c <= r; c++) begin
                if (kind == 4) v = (r == c) ? ($urandom & 32'h7FFF_FFFF) : $urandom;
                else if (r == c) v = (n << FB) + $urandom_range(0, 1 << FB);
                else v = $urandom_range(0, 1 << (FB + 1)) - (1 << FB);
                push_item(ACT_WR_A, r, c, v);
                if (r != c) push_item(ACT_WR_A, c, r, v);
                if ($urandom_range(0, 9) == 0) push_item(ACT_UNUSED, $urandom, $urandom, $urandom);
            end
        end
        if (kind == 1 && n >= 2) begin
            i = $urandom_range(1, n - 1);
            j = $urandom_range(0, i - 1);
            push_item(ACT_WR_A, i, j, gen_a[i][j] + 1);
        end else if (kind == 2) begin
            i = $urandom_range(0, n - 1);
            push_item(ACT_WR_A, i, i, -$urandom_range(1, 1 << 20));
        end else if (kind == 3) begin
            i = $urandom_range(0, n - 1);
            push_item(ACT_WR_A, i, i, 0);
        end
        for (int r = 0; r < n; r++) begin
            v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1 << 21) - (1 << 20);
            push_item(ACT_WR_B, r, $urandom_range(0, 15), v);
        end
        push_solve();
    endtask

    initial begin
        int n;
        int phase;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: single-entry systems at the value extremes and the error cases.
        send_gap_max = 0;
        rx_gap_max = 0;
        set_order(5'd1);
        push_item(ACT_WR_A, 0, 0, 1 << FB);
        push_item(ACT_WR_B, 0, 15, 32'h7FFF_FFFF);
        push_solve();
        push_item(ACT_WR_B, 0, 0, 32'h8000_0000);
        push_solve();
        push_item(ACT_WR_A, 0, 0, 32'h7FFF_FFFF);
        push_item(ACT_WR_B, 0, 0, 1);
        push_solve();
        push_item(ACT_WR_A, 15, 15, 32'hFFFF_FFFF);
        push_item(ACT_WR_A, 15, 0, 32'h5555_AAAA);
        push_item(ACT_WR_B, 15, 15, 32'hAAAA_5555);
        push_item(ACT_UNUSED, 15, 15, 32'hFFFF_FFFF);
        push_item(ACT_WR_A, 0, 0, 0);
        push_solve();
        push_item(ACT_WR_A, 0, 0, -1);
        push_solve();
        push_item(ACT_WR_A, 0, 0, 3 << FB);
        push_solve();
        // Order zero behaves as one.
        set_order(5'd0);
        push_solve();
        // A 2 x 2 system, first asymmetric, then repaired.
        set_order(5'd2);
        push_item(ACT_WR_A, 0, 1, 1 << FB);
        push_item(ACT_WR_A, 1, 0, 2 << FB);
        push_item(ACT_WR_A, 1, 1, 4 << FB);
        push_item(ACT_WR_B, 1, 0, 5 << FB);
        push_solve();
        push_item(ACT_WR_A, 1, 0, 1 << FB);
        push_solve();

        // Largest order, reached through an oversized setting, then the same
        // system solved again at exactly 16.
        send_gap_max = 12;
        rx_gap_max = 12;
        set_order(5'd31);
        load_system(DIM, 0);
        set_order(5'd16);
        push_solve();

        // Random phases, each at its own order and idling mix; the first one holds
        // the output off for a long stretch while the next system is offered.
        phase = 0;
        while (issued < TARGET_ITEMS) begin
            n = $urandom_range(2, 4);
            set_order(n[CFG_W-1:0]);
            send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
            rx_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
            if (phase == 0) long_req++;
            for (int s = 0; s < 2; s++)
                load_system(n, ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 4));
            phase++;
        end
        drain();

        $display("Ran %0d solves over %0d input items in %0d phases;", n_solves, issued, phase);
        $display("%0d solution items checked, %0d of them error reports.", n_results, n_failed);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #4_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

[filelist.f]
rtl/core/chol_pkg.sv
rtl/core/chol_ram.sv
rtl/core/chol_datapath.sv
rtl/core/chol_ctrl.sv
rtl/core/cholesky_linear_solver.sv
rtl/core/chol_checker.sv
tb/cholesky_linear_solver_tb.sv
